[hw/rtl/rfsl_pkg.sv]
// Shared types and constants for the ring FIFO with skip-to-latest.
// Holds the request codes, the controller state type and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package rfsl_pkg;

    localparam int FIELD_W = 32;   // push_data and read_data field width
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_LATEST = 2'd2,
        FN_QUERY  = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

endpackage

[hw/rtl/ring_fifo_with_skip_to_latest.sv]
// Top level of the ring FIFO with skip-to-latest: pointers, request decode, result register.
// Depends on rfsl_pkg and rfsl_ram.
`timescale 1ns / 1ps

// Ring FIFO of DEPTH (a power of two) elements of DATA_WIDTH bits, with free-running
// read and write pointers one bit wider than the index. Each request transaction
// (push, pop oldest, pop to latest, query) yields exactly one result transaction
// carrying ok, the element read and the fill level after the request. A result is
// presented in the cycle after its request is accepted, set by the registered read port
// of the element RAM. The input takes a new request in the same cycle that the
// pending result is taken, so a steady stream runs at one request per cycle; while
// a result is stalled at the output, s_tready is low. No clearing pass follows
// reset: only written entries are ever read.
module ring_fifo_with_skip_to_latest
    import rfsl_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,   // [31:0] push_data
    input  logic [1:0]                       i_s_tuser,   // [1:0] func
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] read_data, then fill_level, zero padding to whole bytes
    output logic [((FIELD_W+$clog2(DEPTH)+1+7)/8)*8-1:0] o_m_tdata,
    output logic [0:0]                       o_m_tuser    // [0] ok
);

    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;
    localparam int OUT_W = ((FIELD_W + PW + 7) / 8) * 8;

    t_state           r_state, n_state;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic             r_ok, n_ok;
    logic             r_has_data, n_has_data;
    logic [PW-1:0]    r_fill, n_fill;

    t_func            w_func;
    logic             w_accept;
    logic [PW-1:0]    w_level;
    logic [PW-1:0]    w_newest;
    logic             w_full, w_empty;
    logic             w_we, w_re;
    logic [AW-1:0]    w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata, w_rdata;
    logic [FIELD_W-1:0]    w_rd_ext;

    assign w_func   = t_func'(i_s_tuser);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_level  = r_wp - r_rp;
    assign w_newest = r_wp - PW'(1);
    assign w_full   = (w_level == PW'(DEPTH));
    assign w_empty  = (w_level == '0);
    assign w_wdata  = DATA_WIDTH'(i_s_tdata);

    // Request decode: pointer update, RAM access and result flags
    always_comb begin
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_ok       = 1'b1;
        n_has_data = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_raddr    = r_rp[AW-1:0];
        case (w_func)
            FN_PUSH: begin
                n_ok = !w_full;
                if (!w_full) begin
                    w_we = w_accept;
                    n_wp = r_wp + PW'(1);
                end
            end
            FN_POP: begin
                n_ok = !w_empty;
                if (!w_empty) begin
                    w_re       = w_accept;
                    n_has_data = 1'b1;
                    n_rp       = r_rp + PW'(1);
                end
            end
            FN_LATEST: begin
                n_ok    = !w_empty;
                w_raddr = w_newest[AW-1:0];
                if (!w_empty) begin
                    // skip ahead: leave only the newest element queued
                    w_re       = w_accept;
                    n_has_data = 1'b1;
                    n_rp       = w_newest;
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
        n_fill = n_wp - n_rp;
    end

    // A write lands at the edge that accepts its push, before any later read is issued, so no forwarding is needed
    rfsl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_m_tready && !w_accept) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_m_tvalid = 1'b0;
        o_s_tready = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_m_tvalid = 1'b0;
                o_s_tready = 1'b1;
            end
            ST_RESP: begin
                o_m_tvalid = 1'b1;
                o_s_tready = i_m_tready;
            end
            default: begin
                o_m_tvalid = 1'b0;
                o_s_tready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_rp <= n_rp;
                r_wp <= n_wp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok       <= n_ok;
            r_has_data <= n_has_data;
            r_fill     <= n_fill;
        end
    end

    assign w_rd_ext  = r_has_data ? FIELD_W'(w_rdata) : '0;
    assign o_m_tdata = OUT_W'({r_fill, w_rd_ext});
    assign o_m_tuser = r_ok;

endmodule

[hw/rtl/rfsl_ram.sv]
// Generic simple dual-port RAM, one write and one read port, registered read.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module rfsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rfsl_chk.sv]
// Port-level checker for ring_fifo_with_skip_to_latest, attached by bind.
// Depends on rfsl_pkg.
`timescale 1ns / 1ps

module rfsl_chk
    import rfsl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [1:0]                       i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [((FIELD_W+$clog2(DEPTH)+1+7)/8)*8-1:0] o_m_tdata,
    input logic [0:0]                       o_m_tuser
);

    localparam int PW = $clog2(DEPTH) + 1;

    logic [PW-1:0] w_fill;
    assign w_fill = o_m_tdata[FIELD_W+PW-1:FIELD_W];

    // every accepted transaction shows its result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("no result after accepted request");

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == FN_QUERY)
        |=> (o_m_tuser[0] && o_m_tdata[FIELD_W-1:0] == '0))
        else $error("query result must be ok with zero data");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_fill <= PW'(DEPTH)))
        else $error("fill level beyond depth");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[FIELD_W-1:0] == '0))
        else $error("refused request returned data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind ring_fifo_with_skip_to_latest rfsl_chk #(.DEPTH(DEPTH)) u_rfsl_chk (.*);

[tb/testbench.sv]
// Self-checking testbench for the ring FIFO with skip-to-latest: a directed table,
// then random request traffic with random gaps on both stream sides, checked against
// an in-bench FIFO predictor. Depends on rfsl_pkg and ring_fifo_with_skip_to_latest.
`timescale 1ns / 1ps

module testbench;
    import rfsl_pkg::*;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = $clog2(DEPTH) + 1;
    localparam int FILL_W   = $clog2(DEPTH) + 1;
    localparam int TDATA_W  = ((FIELD_W + FILL_W + 7) / 8) * 8;
    localparam int N_RANDOM = 850;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] data;
        logic [FILL_W-1:0]  fill;
    } t_result;

    typedef struct packed {
        t_func              func;
        logic [FIELD_W-1:0] data;
        int                 reps;    // data advances by one on each repeat
        logic               typed;   // use the hand-written result below
        t_result            result;
    } t_row;

    localparam int N_ROWS = 17;
    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{FN_QUERY,  32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd0}},
        '{FN_POP,    32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0000_0000, 5'd0}},
        '{FN_LATEST, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0000_0000, 5'd0}},
        '{FN_PUSH,   32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd1}},
        '{FN_PUSH,   32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd2}},
        '{FN_POP,    32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd1}},
        '{FN_POP,    32'h0000_0000, 1,  1'b1, '{1'b1, 32'hFFFF_FFFF, 5'd0}},
        '{FN_POP,    32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0000_0000, 5'd0}},
        '{FN_PUSH,   32'h1234_5678, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd1}},
        '{FN_LATEST, 32'h0000_0000, 1,  1'b1, '{1'b1, 32'h1234_5678, 5'd1}},
        '{FN_POP,    32'h0000_0000, 1,  1'b1, '{1'b1, 32'h1234_5678, 5'd0}},
        '{FN_PUSH,   32'h5555_5550, 16, 1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
        '{FN_PUSH,   32'hAAAA_AAAA, 1,  1'b1, '{1'b0, 32'h0000_0000, 5'd16}},
        '{FN_QUERY,  32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0000_0000, 5'd16}},
        '{FN_LATEST, 32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h5555_555F, 5'd1}},
        '{FN_POP,    32'h0000_0000, 1,  1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
        '{FN_POP,    32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0000_0000, 5'd0}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [31:0]        i_s_tdata;   // [31:0] push_data
    logic [1:0]         i_s_tuser;   // [1:0] func
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [TDATA_W-1:0] o_m_tdata;   // [31:0] read_data, [36:32] fill_level, padding
    logic [0:0]         o_m_tuser;   // [0] ok

    ring_fifo_with_skip_to_latest #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (FIELD_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // FIFO predictor state
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [FIELD_W-1:0] slots [DEPTH];

    t_result pending_results [$];
    int      error_count;
    bit      calm;         // no idling on either side while set
    int      stall_left;
    logic    req_typed;    // travels with the request being driven
    t_result req_result;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic t_result fifo_step(input t_func func, input logic [FIELD_W-1:0] data);
        t_result          res;
        logic [PTR_W-1:0] level;
        logic [PTR_W-1:0] newest;
        res    = '0;
        level  = wr_ptr - rd_ptr;
        newest = wr_ptr - 1'b1;
        case (func)
            FN_PUSH: begin
                if (level < DEPTH) begin
                    slots[wr_ptr[PTR_W-2:0]] = data;
                    wr_ptr = wr_ptr + 1'b1;
                    res.ok = 1'b1;
                end
            end
            FN_POP: begin
                if (level != 0) begin
                    res.data = slots[rd_ptr[PTR_W-2:0]];
                    rd_ptr   = rd_ptr + 1'b1;
                    res.ok   = 1'b1;
                end
            end
            FN_LATEST: begin
                // jump the reader to the newest entry, leaving it queued
                if (level != 0) begin
                    res.data = slots[newest[PTR_W-2:0]];
                    rd_ptr   = newest;
                    res.ok   = 1'b1;
                end
            end
            default: res.ok = 1'b1;
        endcase
        res.fill = wr_ptr - rd_ptr;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Result sink with random stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Check results first, then predict for the request taken at the same edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.ok   = o_m_tuser[0];
                got.data = o_m_tdata[FIELD_W-1:0];
                got.fill = o_m_tdata[FIELD_W +: FILL_W];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none pending", {got}, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
                    if (got.data !== want.data) report_mismatch("read_data", got.data, want.data);
                    if (got.fill !== want.fill) report_mismatch("fill_level", got.fill, want.fill);
                    if (o_m_tdata[TDATA_W-1:FIELD_W+FILL_W] !== '0)
                        report_mismatch("tdata padding", o_m_tdata[TDATA_W-1:FIELD_W+FILL_W], 0);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                predicted = fifo_step(t_func'(i_s_tuser), i_s_tdata);
                pending_results.push_back(req_typed ? req_result : predicted);
            end
        end
    end

    // Start at a clock edge; return at the edge where the request is taken.
    task automatic send_request(input t_func func, input logic [FIELD_W-1:0] data,
                                input logic typed, input t_result result);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= func;
        req_typed  <= typed;
        req_result <= result;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic t_func pick_func(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return r < 65 ? FN_PUSH : r < 80 ? FN_POP : r < 85 ? FN_LATEST : FN_QUERY;
            1:       return r < 15 ? FN_PUSH : r < 80 ? FN_POP : r < 85 ? FN_LATEST : FN_QUERY;
            2:       return r < 35 ? FN_PUSH : r < 70 ? FN_POP : r < 85 ? FN_LATEST : FN_QUERY;
            default: return r < 40 ? FN_PUSH : r < 60 ? FN_POP : r < 90 ? FN_LATEST : FN_QUERY;
        endcase
    endfunction

    initial begin
        int                 sent;
        int                 burst;
        int                 mode;
        int                 waited;
        logic [FIELD_W-1:0] value;
        t_func              func;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = FN_QUERY;
        i_m_tready  = 1'b0;
        req_typed   = 1'b0;
        req_result  = '0;
        calm        = 1'b0;
        stall_left  = 0;
        error_count = 0;
        rd_ptr      = '0;
        wr_ptr      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            for (int k = 0; k < DIR_ROWS[i].reps; k++)
                send_request(DIR_ROWS[i].func, DIR_ROWS[i].data + k,
                             DIR_ROWS[i].typed, DIR_ROWS[i].result);
        end

        // Bursts of biased traffic drive the level through full, empty and wrap
        sent = 0;
        while (sent < N_RANDOM) begin
            mode  = $urandom_range(0, 3);
            burst = $urandom_range(10, 60);
            calm  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                func = pick_func(mode);
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom();
                endcase
                send_request(func, value, 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        // let the monitor queue the prediction for the last transaction
        @(posedge i_clk);
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
